// ----- rtl/lnm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lnm_pkg;

    localparam int RES_W  = 32;
    localparam int Q_W    = 32;
    localparam int PROD_W = 2 * RES_W;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SRC_LOW   = 2'd1;
    localparam logic [1:0] ST_LOAD_LOW  = 2'd2;
    localparam logic [1:0] ST_ZERO_RES  = 2'd3;

    localparam logic KIND_HIGH = 1'b0;
    localparam logic KIND_LOW  = 1'b1;

    typedef struct packed {
        logic [RES_W-1:0] source_resistance;
        logic [RES_W-1:0] load_resistance;
        logic             kind;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [Q_W-1:0]   loaded_q;
        logic [RES_W-1:0] first_reactance;
        logic [RES_W-1:0] second_reactance;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             kind;
        logic [RES_W-1:0] sel;
        logic [RES_W-1:0] d;
    } ctx_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [RES_W-1:0] lo;
    } ctx_lo_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [RES_W-1:0] s;
    } ctx_s_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             kind;
        logic [RES_W-1:0] s;
        logic [Q_W-1:0]   q;
    } fin_t;

endpackage

`default_nettype wire

// ----- rtl/lnm_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lnm_div_pipe #(
    parameter int SIDE_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [lnm_pkg::PROD_W-1:0]  dividend,
    input  wire logic [lnm_pkg::RES_W-1:0]   divisor,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_valid,
    output logic [lnm_pkg::PROD_W-1:0]       quotient,
    output logic [SIDE_W-1:0]                out_side
);
    import lnm_pkg::*;

    localparam int N = PROD_W;

    logic [RES_W-1:0]  rem_reg  [0:N-1];
    logic [N-1:0]      w_reg    [0:N-1];
    logic [RES_W-1:0]  dvs_reg  [0:N-1];
    logic [SIDE_W-1:0] side_reg [0:N-1];
    logic [N-1:0]      vld_reg;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [RES_W-1:0]  rem_in;
        logic [N-1:0]      w_in;
        logic [RES_W-1:0]  dvs_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [RES_W:0]    shifted;
        logic              fits;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign w_in    = dividend;
            assign dvs_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign w_in    = w_reg[i-1];
            assign dvs_in  = dvs_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        assign shifted = {rem_in, w_in[N-1]};
        assign fits    = shifted >= {1'b0, dvs_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fits ? RES_W'(shifted - {1'b0, dvs_in}) : shifted[RES_W-1:0];
                w_reg[i]    <= {w_in[N-2:0], fits};
                dvs_reg[i]  <= dvs_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quotient  = w_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/lnm_isqrt_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lnm_isqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [lnm_pkg::PROD_W-1:0]  radicand,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_valid,
    output logic [lnm_pkg::Q_W-1:0]          root,
    output logic [SIDE_W-1:0]                out_side
);
    import lnm_pkg::*;

    localparam int N = PROD_W / 2;

    logic [PROD_W-1:0] v_reg    [0:N-1];
    logic [PROD_W-1:0] r_reg    [0:N-1];
    logic [SIDE_W-1:0] side_reg [0:N-1];
    logic [N-1:0]      vld_reg;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (PROD_W - 2 - 2 * i);

        logic [PROD_W-1:0] v_in;
        logic [PROD_W-1:0] r_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [PROD_W-1:0] trial;
        logic              fits;

        if (i == 0) begin : g_first
            assign v_in    = radicand;
            assign r_in    = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        assign trial = r_in + BIT;
        assign fits  = v_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= fits ? v_in - trial : v_in;
                r_reg[i]    <= fits ? (r_in >> 1) + BIT : r_in >> 1;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = r_reg[N-1][Q_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/l_network_match_designer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// L-network matching designer. Each word gives source and load resistance
// (unsigned Q24.8) and a topology; the result word gives status, Q (Q16.16)
// and the two reactances (Q24.8), all zero on error. One word enters per
// cycle unless held; it passes through decode, two 64-stage restoring dividers,
// two 32-stage square-root pipes, two multiply stages and the output
// register. The whole pipeline holds while a finished word waits for out_ready.

module l_network_match_designer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lnm_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lnm_pkg::out_word_t      out_word
);
    import lnm_pkg::*;

    logic en;

    logic             dec_vld_reg;
    ctx_lo_t          dec_reg;
    ctx_lo_t          dec_next;

    logic             mul1_vld_reg;
    ctx_lo_t          mul1_side_reg;
    logic [PROD_W-1:0] mul1_prod_reg;

    logic             sq1_vld;
    logic [Q_W-1:0]   sq1_root;
    ctx_lo_t          sq1_side;

    logic             div1_vld;
    logic [PROD_W-1:0] div1_quot;
    ctx_s_t           div1_side;

    logic             sq2_vld;
    logic [Q_W-1:0]   sq2_root;
    ctx_s_t           sq2_side;

    logic             mul2_vld_reg;
    fin_t             mul2_side_reg;
    logic [PROD_W-1:0] mul2_prod_reg;
    logic [RES_W-1:0] mul2_d_reg;

    logic             div2_vld;
    logic [PROD_W-1:0] div2_quot;
    fin_t             div2_side;

    logic [RES_W-1:0] x_sat;
    out_word_t        out_next;
    logic             out_vld_reg;
    out_word_t        out_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // decode: checks and ordering of the two resistances
    always_comb
    begin
        logic [RES_W-1:0] hi;
        logic [RES_W-1:0] lo;
        hi = in_word.source_resistance;
        lo = in_word.load_resistance;
        dec_next.ctx.kind   = in_word.kind;
        dec_next.ctx.status = ST_OK;
        if (in_word.kind == KIND_LOW)
        begin
            hi = in_word.load_resistance;
            lo = in_word.source_resistance;
        end
        if (in_word.source_resistance == '0 || in_word.load_resistance == '0)
        begin
            dec_next.ctx.status = ST_ZERO_RES;
        end else if ({1'b0, hi} < {lo, 1'b0})
        begin
            dec_next.ctx.status = (in_word.kind == KIND_LOW) ? ST_LOAD_LOW : ST_SRC_LOW;
        end
        dec_next.ctx.sel = (in_word.kind == KIND_LOW) ? in_word.load_resistance
                                                      : in_word.source_resistance;
        dec_next.ctx.d   = hi - lo;
        dec_next.lo      = lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_vld_reg  <= 1'b0;
            mul1_vld_reg <= 1'b0;
            mul2_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else if (en)
        begin
            dec_vld_reg  <= in_valid;
            mul1_vld_reg <= dec_vld_reg;
            mul2_vld_reg <= sq2_vld;
            out_vld_reg  <= div2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg       <= dec_next;
            mul1_side_reg <= dec_reg;
            mul1_prod_reg <= PROD_W'(dec_reg.lo) * PROD_W'(dec_reg.ctx.d);
            mul2_side_reg.status <= sq2_side.ctx.status;
            mul2_side_reg.kind   <= sq2_side.ctx.kind;
            mul2_side_reg.s      <= sq2_side.s;
            mul2_side_reg.q      <= sq2_root;
            mul2_d_reg           <= sq2_side.ctx.d;
            mul2_prod_reg <= PROD_W'(sq2_side.s) * PROD_W'(sq2_side.ctx.sel);
            out_reg       <= out_next;
        end
    end

    // S = isqrt(L * D)
    lnm_isqrt_pipe #(.SIDE_W($bits(ctx_lo_t))) u_sqrt_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mul1_vld_reg),
        .radicand  (mul1_prod_reg),
        .in_side   (mul1_side_reg),
        .out_valid (sq1_vld),
        .root      (sq1_root),
        .out_side  (sq1_side)
    );

    // D * 2^32 / L
    lnm_div_pipe #(.SIDE_W($bits(ctx_s_t))) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq1_vld),
        .dividend  ({sq1_side.ctx.d, RES_W'(0)}),
        .divisor   (sq1_side.lo),
        .in_side   ({sq1_side.ctx, sq1_root}),
        .out_valid (div1_vld),
        .quotient  (div1_quot),
        .out_side  (div1_side)
    );

    // Q = isqrt(ratio)
    lnm_isqrt_pipe #(.SIDE_W($bits(ctx_s_t))) u_sqrt_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div1_vld),
        .radicand  (div1_quot),
        .in_side   (div1_side),
        .out_valid (sq2_vld),
        .root      (sq2_root),
        .out_side  (sq2_side)
    );

    // S * (Rs or Rl) / D
    lnm_div_pipe #(.SIDE_W($bits(fin_t))) u_div_react (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mul2_vld_reg),
        .dividend  (mul2_prod_reg),
        .divisor   (mul2_d_reg),
        .in_side   (mul2_side_reg),
        .out_valid (div2_vld),
        .quotient  (div2_quot),
        .out_side  (div2_side)
    );

    assign x_sat = (div2_quot[PROD_W-1:RES_W] != '0) ? '1 : div2_quot[RES_W-1:0];

    always_comb
    begin
        out_next.status           = div2_side.status;
        out_next.loaded_q         = '0;
        out_next.first_reactance  = '0;
        out_next.second_reactance = '0;
        if (div2_side.status == ST_OK)
        begin
            out_next.loaded_q = div2_side.q;
            if (div2_side.kind == KIND_LOW)
            begin
                out_next.first_reactance  = x_sat;
                out_next.second_reactance = div2_side.s;
            end else
            begin
                out_next.first_reactance  = div2_side.s;
                out_next.second_reactance = x_sat;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_word  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status != ST_OK |->
            out_word.loaded_q == '0 && out_word.first_reactance == '0 &&
            out_word.second_reactance == '0)
        else $error("error word carries nonzero results");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == ST_OK |->
            out_word.loaded_q[Q_W-1:Q_W/2] != '0 && out_word.first_reactance != '0 &&
            out_word.second_reactance != '0)
        else $error("valid match gives Q below one or zero reactance");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("pipeline advance disagrees with output stall");

endmodule

`default_nettype wire
